[hw/rtl/hsc_pkg.sv]
// Shared types, constants and position helpers for the Hamming SEC codec.
package hsc_pkg;

    localparam int MAX_N     = 63;
    localparam int WORD_W    = 63;
    localparam int LEN_W     = 6;
    localparam int SYN_W     = 6;
    localparam int PCNT_W    = 3;
    localparam int OPCODE_W  = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [OPCODE_W-1:0] OP_ENCODE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DECODE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CHECK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CODE_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_LENGTH = 1'd1;

    localparam logic [LEN_W-1:0] CODE_LENGTH_RST = 6'd7;
    localparam logic [LEN_W-1:0] DATA_LENGTH_RST = 6'd4;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [WORD_W-1:0]   word_in;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0] word_out;
        logic [PCNT_W-1:0] parity_count;
        logic              codeword_ok;
        logic              status;
    } t_rsp;

    function automatic logic is_pow2(input int pos);
        return (pos != 0) && ((pos & (pos - 1)) == 0);
    endfunction

    // index of the data bit carried at a non-power-of-two position
    function automatic logic [LEN_W-1:0] data_idx(input int pos);
        int cnt;
        cnt = 0;
        for (int j = 1; j <= pos; j = j * 2) begin
            cnt = cnt + 1;
        end
        return LEN_W'(pos - 1 - cnt);
    endfunction

    function automatic logic [SYN_W-1:0] syndrome(input logic [WORD_W-1:0] cw);
        logic [SYN_W-1:0] s;
        s = '0;
        for (int i = 1; i <= MAX_N; i++) begin
            if (cw[i-1]) begin
                s = s ^ SYN_W'(i);
            end
        end
        return s;
    endfunction

endpackage

[hw/rtl/hamming_sec_codec.sv]
// Hamming single-error-correcting encoder, decoder and checker, top level.
// A request taken with start is registered in r_req; its result is registered in r_rsp (o_valid high).
// Throughput: one request per cycle through one XOR-tree stage; busy is always low.
// Reset (synchronous, active low): pipeline emptied, code_length 7, data_length 4.
// Results are shown for one cycle only; the receiver cannot stall.
module hamming_sec_codec import hsc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_req                 i_req,
    output logic                 o_valid,
    output t_rsp                 o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LEN_W-1:0]     i_cfg_data
);

    logic [LEN_W-1:0] r_code_len;
    logic [LEN_W-1:0] r_data_len;
    logic             r_req_vld;
    t_req             r_req;
    logic             r_vld;
    t_rsp             r_rsp;
    t_rsp             n_rsp;

    logic [WORD_W-1:0] len_mask;
    logic [WORD_W-1:0] enc_data;
    logic [WORD_W-1:0] enc_word;
    logic [SYN_W-1:0]  enc_syn;
    logic [WORD_W-1:0] dec_cw;
    logic [SYN_W-1:0]  dec_syn;
    logic [WORD_W-1:0] dec_fix;
    logic [WORD_W-1:0] dec_data;
    logic [PCNT_W-1:0] pcnt;
    logic [LEN_W-1:0]  len_diff;
    logic              params_ok;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_len <= CODE_LENGTH_RST;
            r_data_len <= DATA_LENGTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CODE_LENGTH: r_code_len <= i_cfg_data;
                CFG_DATA_LENGTH: r_data_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_vld     <= 1'b0;
        end else begin
            r_req_vld <= start && !busy;
            r_vld     <= r_req_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_req;
        end
        if (r_req_vld) begin
            r_rsp <= n_rsp;
        end
    end

    always_comb begin
        len_mask = '0;
        enc_data = '0;
        for (int i = 1; i <= MAX_N; i++) begin
            len_mask[i-1] = (i <= int'(r_code_len));
            if (!is_pow2(i) && (i <= int'(r_code_len)) && (data_idx(i) < r_data_len)) begin
                enc_data[i-1] = r_req.word_in[data_idx(i)];
            end
        end
    end

    assign enc_syn = syndrome(enc_data);

    always_comb begin
        enc_word = enc_data;
        for (int j = 0; j < SYN_W; j++) begin
            if ((1 << j) <= int'(r_code_len)) begin
                enc_word[(1 << j) - 1] = enc_syn[j];
            end
        end
    end

    assign len_diff = r_code_len - r_data_len;

    always_comb begin
        if (r_data_len > r_code_len) begin
            params_ok = 1'b0;
        end else if (len_diff >= LEN_W'(SYN_W)) begin
            params_ok = 1'b1;
        end else begin
            params_ok = ((7'd1 << len_diff) >= ({1'b0, r_code_len} + 7'd1));
        end
    end

    assign dec_cw  = r_req.word_in & len_mask;
    assign dec_syn = syndrome(dec_cw);

    always_comb begin
        dec_fix  = dec_cw;
        dec_data = '0;
        for (int i = 1; i <= MAX_N; i++) begin
            if ((int'(dec_syn) == i) && (i <= int'(r_code_len))) begin
                dec_fix[i-1] = ~dec_cw[i-1];
            end
        end
        for (int i = 1; i <= MAX_N; i++) begin
            if (!is_pow2(i)) begin
                dec_data[data_idx(i)] = dec_fix[i-1];
            end
        end
    end

    // bit length of n, i.e. smallest r with 2^r >= n + 1
    always_comb begin
        pcnt = '0;
        for (int j = 0; j < LEN_W; j++) begin
            if (r_code_len[j]) begin
                pcnt = PCNT_W'(j + 1);
            end
        end
    end

    always_comb begin
        n_rsp              = '0;
        n_rsp.parity_count = pcnt;
        case (r_req.opcode)
            OP_ENCODE: begin
                if (params_ok) begin
                    n_rsp.word_out = enc_word;
                end else begin
                    n_rsp.status = 1'b1;
                end
            end
            OP_DECODE: n_rsp.word_out = dec_data;
            OP_CHECK:  n_rsp.codeword_ok = (dec_syn == '0);
            default: ;
        endcase
    end

    assign o_valid = r_vld;
    assign o_rsp   = r_rsp;

endmodule

[bench/hamming_sec_codec_test.sv]
// Self-checking testbench for the Hamming single-error-correcting codec.
`timescale 1ns / 100ps

module hamming_sec_codec_test;
    import hsc_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int MAX_PRINTED = 50;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    t_req                 i_req = '0;
    logic                 o_valid;
    t_rsp                 o_rsp;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [LEN_W-1:0]     i_cfg_data = '0;

    t_rsp             expected_rsps[$];
    logic [LEN_W-1:0] cfg_code_len;
    logic [LEN_W-1:0] cfg_data_len;
    int               requests_sent = 0;
    int               results_seen = 0;
    int               error_count = 0;
    int               idle_cycles = 0;
    int               sender_idle_pct = 0;

    hamming_sec_codec uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int codeword_syndrome(input logic [WORD_W-1:0] cw, input int n);
        int syn;
        syn = 0;
        for (int p = 1; p <= n; p++) begin
            if (cw[p-1]) begin
                syn ^= p;
            end
        end
        return syn;
    endfunction

    function automatic t_rsp predict_codec(input t_req req, input int n, input int m);
        t_rsp              rsp;
        logic [WORD_W-1:0] cw;
        int                syn;
        int                k;
        int                r;
        rsp = '0;
        if (n > MAX_N) begin
            n = MAX_N;
        end
        r = 0;
        while ((1 << r) < n + 1) begin
            r++;
        end
        rsp.parity_count = PCNT_W'(r);
        case (req.opcode)
            OP_ENCODE: begin
                if (m > n || (n - m < 7 && (1 << (n - m)) < n + 1)) begin
                    rsp.status = 1'b1;
                end else begin
                    cw = '0;
                    syn = 0;
                    k = 0;
                    for (int p = 1; p <= n; p++) begin
                        if ((p & (p - 1)) != 0) begin
                            if (k < m && req.word_in[k]) begin
                                cw[p-1] = 1'b1;
                                syn ^= p;
                            end
                            k++;
                        end
                    end
                    for (int p = 1; p <= n; p = p * 2) begin
                        if ((syn & p) != 0) begin
                            cw[p-1] = 1'b1;
                        end
                    end
                    rsp.word_out = cw;
                end
            end
            OP_DECODE: begin
                cw = req.word_in;
                syn = codeword_syndrome(cw, n);
                if (syn >= 1 && syn <= n) begin
                    cw[syn-1] = ~cw[syn-1];
                end
                k = 0;
                for (int p = 1; p <= n; p++) begin
                    if ((p & (p - 1)) != 0) begin
                        rsp.word_out[k] = cw[p-1];
                        k++;
                    end
                end
            end
            OP_CHECK: begin
                rsp.codeword_ok = (codeword_syndrome(req.word_in, n) == 0);
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        if (error_count < MAX_PRINTED) begin
            $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
        end
        error_count++;
    endtask

    // result checker, request predictor, config shadow and watchdog
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            cfg_code_len = CODE_LENGTH_RST;
            cfg_data_len = DATA_LENGTH_RST;
            idle_cycles = 0;
        end else begin
            if (o_valid) begin
                if (expected_rsps.size() == 0) begin
                    report_mismatch("result with no request pending", o_rsp.word_out, '0);
                end else begin
                    want = expected_rsps.pop_front();
                    if (o_rsp.word_out !== want.word_out)
                        report_mismatch("word_out", o_rsp.word_out, want.word_out);
                    if (o_rsp.parity_count !== want.parity_count)
                        report_mismatch("parity_count", WORD_W'(o_rsp.parity_count),
                                        WORD_W'(want.parity_count));
                    if (o_rsp.codeword_ok !== want.codeword_ok)
                        report_mismatch("codeword_ok", WORD_W'(o_rsp.codeword_ok),
                                        WORD_W'(want.codeword_ok));
                    if (o_rsp.status !== want.status)
                        report_mismatch("status", WORD_W'(o_rsp.status), WORD_W'(want.status));
                end
                results_seen++;
            end
            if (start && !busy) begin
                expected_rsps.insert(expected_rsps.size(),
                                     predict_codec(i_req, int'(cfg_code_len),
                                                   int'(cfg_data_len)));
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_CODE_LENGTH) begin
                    cfg_code_len = i_cfg_data;
                end else if (i_cfg_idx == CFG_DATA_LENGTH) begin
                    cfg_data_len = i_cfg_data;
                end
            end
            if ((start && !busy) || o_valid || i_cfg_we) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [WORD_W-1:0] word);
        t_req req;
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        req.opcode = op;
        req.word_in = word;
        i_req <= req;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        requests_sent++;
    endtask

    task automatic wait_for_drain();
        start <= 1'b0;
        while (results_seen < requests_sent) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_lengths(input int n, input int m);
        wait_for_drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_CODE_LENGTH;
        i_cfg_data <= LEN_W'(n);
        @(posedge i_clk);
        i_cfg_idx <= CFG_DATA_LENGTH;
        i_cfg_data <= LEN_W'(m);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_default_lengths();
        send_request(OP_ENCODE, {59'h7FF_FFFF_FFFF_FFFF, 4'hB});
        send_request(OP_ENCODE, '1);
        send_request(OP_DECODE, 63'h7F);
        send_request(OP_DECODE, 63'h77);
        send_request(OP_CHECK, 63'h7F);
        send_request(OP_CHECK, 63'h7E);
        send_request(OP_UNUSED, '1);
    endtask

    task automatic test_longest_code();
        set_lengths(63, 57);
        send_request(OP_ENCODE, '1);
        send_request(OP_ENCODE, '0);
        send_request(OP_ENCODE, {32'h5555_5555, 31'h2AAA_AAAA});
        send_request(OP_DECODE, '1);
        send_request(OP_DECODE, 63'h3FFF_FFFF_FFFF_FFFF);
        send_request(OP_CHECK, '1);
        send_request(OP_CHECK, 63'h4000_0000_0000_0000);
    endtask

    task automatic test_invalid_lengths();
        set_lengths(63, 63);
        send_request(OP_ENCODE, '1);
        set_lengths(3, 5);
        send_request(OP_ENCODE, '1);
    endtask

    task automatic test_empty_code();
        set_lengths(0, 0);
        send_request(OP_ENCODE, '1);
        send_request(OP_DECODE, '1);
        send_request(OP_CHECK, '1);
    endtask

    task automatic test_syndrome_beyond_length();
        // positions 3 and 4 give syndrome 7, past n = 5
        set_lengths(5, 2);
        send_request(OP_DECODE, 63'h0C);
        send_request(OP_CHECK, 63'h0C);
    endtask

    task automatic send_random_request();
        t_rsp                enc;
        t_req                data_req;
        logic [WORD_W-1:0]   word;
        logic [WORD_W-1:0]   noise;
        logic [OPCODE_W-1:0] op;
        int                  sel;
        int                  kind;
        int                  n;
        int                  r;
        n = int'(cfg_code_len);
        enc = predict_codec('0, n, 0);
        r = int'(enc.parity_count);
        sel = $urandom_range(99);
        noise = WORD_W'({$urandom, $urandom});
        if (sel < 30) op = OP_ENCODE;
        else if (sel < 70) op = OP_DECODE;
        else if (sel < 95) op = OP_CHECK;
        else op = OP_UNUSED;
        if (op == OP_ENCODE) begin
            word = ($urandom_range(9) == 0) ? '1 : noise;
        end else begin
            data_req.opcode = OP_ENCODE;
            data_req.word_in = WORD_W'({$urandom, $urandom});
            enc = predict_codec(data_req, n, n - r);
            word = enc.word_out;
            kind = $urandom_range(9);
            // clean, one flipped bit, two flipped bits, noise, junk above n
            if (kind >= 3 && kind <= 7 && n > 0) word[$urandom_range(n - 1, 0)] ^= 1'b1;
            if (kind == 7 && n > 0) word[$urandom_range(n - 1, 0)] ^= 1'b1;
            if (kind == 8) word = noise;
            if (kind == 9) word |= noise & ~((WORD_W'(1) << n) - 1);
        end
        send_request(op, word);
    endtask

    task automatic test_random_traffic();
        int   idle_pcts[4];
        t_rsp pc_rsp;
        int   n;
        int   m;
        int   r;
        idle_pcts = '{0, 65, 33, 0};
        foreach (idle_pcts[ph]) begin
            sender_idle_pct = idle_pcts[ph];
            repeat (5) begin
                n = $urandom_range(63, 0);
                pc_rsp = predict_codec('0, n, 0);
                r = int'(pc_rsp.parity_count);
                if ($urandom_range(9) < 7) m = $urandom_range(n - r, 0);
                else m = $urandom_range(63, 0);
                set_lengths(n, m);
                repeat (82) send_random_request();
            end
        end
        sender_idle_pct = 0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_lengths();
        test_longest_code();
        test_invalid_lengths();
        test_empty_code();
        test_syndrome_beyond_length();
        test_random_traffic();
        wait_for_drain();
        repeat (4) @(posedge i_clk);
        if (error_count == 0 && expected_rsps.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/hsc_pkg.sv
hw/rtl/hamming_sec_codec.sv
bench/hamming_sec_codec_test.sv
